@@ src/lrupr_pkg.sv @@
// Shared constants, types and control records for the LRU page replacement block.
// No dependencies; every other file imports this package.
package lrupr_pkg;

    // Build size
    localparam int NUM_FRAMES = 16;
    localparam int PAGE_WIDTH = 16;
    localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

    // Field widths fixed by the channel definitions
    localparam int PAGE_FIELD_W = 16;
    localparam int SLOT_W       = 4;
    localparam int CNT_W        = 32;
    localparam int CFG_W        = 5;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // Search record that travels down the cell chain, one cell a cycle
    typedef struct packed {
        logic                  tok;
        logic                  hit_found;
        logic [IDX_W-1:0]      hit_idx;
        logic                  empty_found;
        logic [IDX_W-1:0]      empty_idx;
        logic                  min_found;
        logic [CNT_W-1:0]      min_stamp;
        logic [IDX_W-1:0]      min_idx;
        logic [PAGE_WIDTH-1:0] min_page;
    } scan_t;

    // Update broadcast from the controller to every cell
    typedef struct packed {
        logic                  wr;
        logic                  clr;
        logic [IDX_W-1:0]      slot;
        logic                  set_valid;
        logic [PAGE_WIDTH-1:0] page;
        logic [CNT_W-1:0]      stamp;
    } cmd_t;

endpackage

@@ src/lrupr_if.sv @@
// Handshake channels of the LRU page replacement block: request, response, config write.
// Depends on lrupr_pkg for field widths.
interface lrupr_req_if;
    import lrupr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [PAGE_FIELD_W-1:0] page_number;
    logic                    last_ref;

    modport source (output valid, output page_number, output last_ref, input ready);
    modport sink   (input valid, input page_number, input last_ref, output ready);
endinterface

interface lrupr_rsp_if;
    import lrupr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic [SLOT_W-1:0]       frame_slot;
    logic                    replaced_valid;
    logic [PAGE_FIELD_W-1:0] replaced_page;
    logic [CNT_W-1:0]        fault_count;

    modport source (output valid, output hit, output frame_slot, output replaced_valid,
                    output replaced_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input frame_slot, input replaced_valid,
                    input replaced_page, input fault_count, output ready);
endinterface

interface lrupr_cfg_if;
    import lrupr_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

@@ src/lrupr_cell.sv @@
// One page frame of the chain: page, valid mark and last-use stamp, plus one search stage.
// Depends on lrupr_pkg (scan_t, cmd_t).
module lrupr_cell
    import lrupr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      cell_index,
    input  logic [IDX_W-1:0]      last_idx,
    input  logic [PAGE_WIDTH-1:0] req_page,
    input  scan_t                 scan_in,
    output scan_t                 scan_out,
    input  cmd_t                  cmd
);

    logic [PAGE_WIDTH-1:0] page_reg;
    logic [CNT_W-1:0]      stamp_reg;
    logic                  valid_reg;
    scan_t                 scan_reg;
    scan_t                 scan_next;
    logic                  active;

    assign active   = (cell_index <= last_idx);
    assign scan_out = scan_reg;

    // Fold this frame into the passing search record
    always_comb
    begin
        scan_next = scan_in;
        // search ends at the last active frame, so no stale token lingers further down
        if (!active)
            scan_next.tok = 1'b0;
        if (scan_in.tok && active)
        begin
            if (!scan_in.hit_found && valid_reg && (page_reg == req_page))
            begin
                scan_next.hit_found = 1'b1;
                scan_next.hit_idx   = cell_index;
            end
            if (!scan_in.empty_found && !valid_reg)
            begin
                scan_next.empty_found = 1'b1;
                scan_next.empty_idx   = cell_index;
            end
            // strict less-than keeps the lowest index on a tie
            if (valid_reg && (!scan_in.min_found || (stamp_reg < scan_in.min_stamp)))
            begin
                scan_next.min_found = 1'b1;
                scan_next.min_stamp = stamp_reg;
                scan_next.min_idx   = cell_index;
                scan_next.min_page  = page_reg;
            end
        end
    end

    // Search stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_reg <= '0;
        else
            scan_reg <= scan_next;
    end

    // Valid mark: cleared at reset and at end of string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.clr)
            valid_reg <= 1'b0;
        else if (cmd.wr && cmd.set_valid && (cmd.slot == cell_index))
            valid_reg <= 1'b1;
    end

    // Frame contents
    always_ff @(posedge clk)
    begin
        if (cmd.wr && (cmd.slot == cell_index))
        begin
            stamp_reg <= cmd.stamp;
            if (cmd.set_valid)
                page_reg <= cmd.page;
        end
    end

endmodule

@@ src/lrupr_ctrl.sv @@
// Sequencer: takes a request, launches a search down the cells, picks hit/fill/evict,
// broadcasts the frame update and holds the response. Depends on lrupr_pkg, lrupr_if.
module lrupr_ctrl
    import lrupr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    lrupr_req_if.sink             req,
    lrupr_rsp_if.source           rsp,
    lrupr_cfg_if.sink             cfg,
    input  scan_t                 scan_tap,
    output scan_t                 scan_head,
    output logic [IDX_W-1:0]      last_idx,
    output logic [PAGE_WIDTH-1:0] req_page,
    output cmd_t                  cmd
);

    state_t                  state_reg, state_next;
    logic [CFG_W-1:0]        frames_reg;
    logic [PAGE_WIDTH-1:0]   page_reg;
    logic                    last_reg;
    logic                    start_reg;
    scan_t                   res_reg;
    logic [CNT_W-1:0]        use_cnt_reg;
    logic [CNT_W-1:0]        fault_reg;

    logic                    out_valid_reg;
    logic                    out_hit_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic                    out_repl_reg;
    logic [PAGE_FIELD_W-1:0] out_repl_page_reg;
    logic [CNT_W-1:0]        out_fault_reg;

    logic                    in_fire;
    logic                    commit;
    logic                    is_hit;
    logic                    evict;
    logic [IDX_W-1:0]        slot;
    logic [CNT_W-1:0]        cnt_inc;
    logic [CNT_W-1:0]        fault_new;

    assign in_fire   = req.valid && req.ready;
    assign req_page  = page_reg;
    assign cfg.ready = 1'b1;

    // Active frame count, clamped to 1..NUM_FRAMES, as the index of the last active cell
    always_comb
    begin
        if (frames_reg == '0)
            last_idx = '0;
        else if (int'(frames_reg) > NUM_FRAMES)
            last_idx = IDX_W'(NUM_FRAMES - 1);
        else
            last_idx = IDX_W'(int'(frames_reg) - 1);
    end

    // Search record entering cell 0
    always_comb
    begin
        scan_head     = '0;
        scan_head.tok = start_reg;
    end

    // Replacement decision from the finished search
    always_comb
    begin
        is_hit    = res_reg.hit_found;
        evict     = !res_reg.hit_found && !res_reg.empty_found;
        if (res_reg.hit_found)
            slot = res_reg.hit_idx;
        else if (res_reg.empty_found)
            slot = res_reg.empty_idx;
        else
            slot = res_reg.min_idx;
        cnt_inc   = use_cnt_reg + CNT_W'(1);
        fault_new = is_hit ? fault_reg : fault_reg + CNT_W'(1);
    end

    // Next state and update broadcast
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_tap.tok)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        cmd.wr        = commit;
        cmd.clr       = commit && last_reg;
        cmd.slot      = slot;
        cmd.set_valid = !is_hit;
        cmd.page      = page_reg;
        cmd.stamp     = cnt_inc;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= FRAMES_RESET;
            start_reg     <= 1'b0;
            use_cnt_reg   <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                frames_reg <= cfg.frames_in_use;
            start_reg <= in_fire;
            if (commit)
            begin
                use_cnt_reg   <= last_reg ? '0 : cnt_inc;
                fault_reg     <= last_reg ? '0 : fault_new;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Request, search result and response payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            page_reg <= PAGE_WIDTH'(req.page_number);
            last_reg <= req.last_ref;
        end
        if ((state_reg == ST_SCAN) && scan_tap.tok)
            res_reg <= scan_tap;
        if (commit)
        begin
            out_hit_reg       <= is_hit;
            out_slot_reg      <= SLOT_W'(slot);
            out_repl_reg      <= evict;
            out_repl_page_reg <= evict ? PAGE_FIELD_W'(res_reg.min_page) : '0;
            out_fault_reg     <= fault_new;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.frame_slot     = out_slot_reg;
    assign rsp.replaced_valid = out_repl_reg;
    assign rsp.replaced_page  = out_repl_page_reg;
    assign rsp.fault_count    = out_fault_reg;

endmodule

@@ src/lru_page_replacement_top.sv @@
// LRU page replacement: one request at a time; a new request is accepted only after the
// previous one has been written back. The search moves one frame cell per cycle down the chain
// of active frames, where active frames is frames_in_use clamped to 1..16.
// A waiting response does not block the next request's search.
// Reset (rst_n, async low): all frames empty, counters zero, frames_in_use = 16.
// Depends on lrupr_pkg, lrupr_if, lrupr_cell, lrupr_ctrl.
module lru_page_replacement_top
    import lrupr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lrupr_req_if.sink   req,
    lrupr_rsp_if.source rsp,
    lrupr_cfg_if.sink   cfg
);

    scan_t                 scan_head;
    scan_t                 scan_out [NUM_FRAMES];
    scan_t                 scan_tap;
    logic [IDX_W-1:0]      last_idx;
    logic [PAGE_WIDTH-1:0] req_page;
    cmd_t                  cmd;

    lrupr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .scan_tap  (scan_tap),
        .scan_head (scan_head),
        .last_idx  (last_idx),
        .req_page  (req_page),
        .cmd       (cmd)
    );

    // Frame cells, search record handed from each to the next
    for (genvar i = 0; i < NUM_FRAMES; i++)
    begin : g_cell
        scan_t cell_in;
        if (i == 0)
        begin : g_head
            assign cell_in = scan_head;
        end
        else
        begin : g_link
            assign cell_in = scan_out[i-1];
        end

        lrupr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(i)),
            .last_idx   (last_idx),
            .req_page   (req_page),
            .scan_in    (cell_in),
            .scan_out   (scan_out[i]),
            .cmd        (cmd)
        );
    end

    // Search is complete at the output of the last active cell
    assign scan_tap = scan_out[last_idx];

`ifndef ASSERT_OFF
    // A hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (!rsp.replaced_valid && (rsp.replaced_page == '0)))
        else $error("hit reported with an evicted page");

    // Only one request is in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while one is in progress");

    // The chosen frame lies within the active frames
    a_slot_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> (cmd.slot <= last_idx))
        else $error("frame update outside the active frames");

    // A fault always bumps the fault count to nonzero
    a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.fault_count != '0))
        else $error("fault reported with zero fault count");
`endif

endmodule

@@ tb/sv/tb_lru_page_replacement_top.sv @@
`timescale 1ns / 1ps
// Testbench for lru_page_replacement_top: directed table, then random reference strings.
// Each response is checked against an in-bench LRU frame predictor or, for typed directed rows, the table's values.
// Depends on lrupr_pkg, lrupr_if and the block's RTL.
module tb_lru_page_replacement_top;
    import lrupr_pkg::*;

    // One expected or observed response
    typedef struct packed {
        logic                    hit;
        logic [SLOT_W-1:0]       frame_slot;
        logic                    replaced_valid;
        logic [PAGE_FIELD_W-1:0] replaced_page;
        logic [CNT_W-1:0]        fault_count;
    } result_t;

    typedef enum logic {
        ROW_REF,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table
    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_W-1:0]        frames;
        logic [PAGE_FIELD_W-1:0] page;
        logic                    last;
        logic                    typed;
        result_t                 want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    lrupr_req_if req_ch ();
    lrupr_rsp_if rsp_ch ();
    lrupr_cfg_if cfg_ch ();

    lru_page_replacement_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state
    logic [PAGE_FIELD_W-1:0] fr_page  [NUM_FRAMES];
    bit                      fr_valid [NUM_FRAMES];
    logic [CNT_W-1:0]        fr_stamp [NUM_FRAMES];
    logic [CNT_W-1:0]        ref_clock;
    logic [CNT_W-1:0]        fault_total;
    logic [CFG_W-1:0]        frames_cfg;

    result_t pending_results [$];
    int      mismatch_count;
    int      resp_seen;
    bit      no_gaps;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void clear_frames();
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            fr_page[i]  = '0;
            fr_valid[i] = 1'b0;
            fr_stamp[i] = '0;
        end
        ref_clock   = '0;
        fault_total = '0;
    endfunction

    // LRU predictor: one reference in, one response out
    function automatic result_t lru_access(input logic [PAGE_FIELD_W-1:0] page,
                                           input logic lst);
        int      n;
        int      slot;
        bit      found;
        bit      is_hit;
        result_t r;
        n      = (frames_cfg == 0) ? 1 : ((frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg);
        r      = '0;
        slot   = 0;
        found  = 1'b0;
        is_hit = 1'b0;
        ref_clock = ref_clock + 1;
        // hit search, lowest index wins on duplicates
        for (int i = 0; i < n && !found; i++)
            if (fr_valid[i] && fr_page[i] == page)
            begin
                slot   = i;
                found  = 1'b1;
                is_hit = 1'b1;
            end
        // lowest empty active frame
        for (int i = 0; i < n && !found; i++)
            if (!fr_valid[i])
            begin
                slot  = i;
                found = 1'b1;
            end
        // evict smallest stamp, lowest index on a tie
        if (!found)
        begin
            slot = 0;
            for (int i = 1; i < n; i++)
                if (fr_stamp[i] < fr_stamp[slot])
                    slot = i;
            r.replaced_valid = 1'b1;
            r.replaced_page  = fr_page[slot];
        end
        if (!is_hit)
        begin
            fault_total    = fault_total + 1;
            fr_page[slot]  = page;
            fr_valid[slot] = 1'b1;
        end
        fr_stamp[slot] = ref_clock;
        r.hit          = is_hit;
        r.frame_slot   = slot[SLOT_W-1:0];
        r.fault_count  = fault_total;
        if (lst)
            clear_frames();
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic dir_row_t ref_row(input logic [PAGE_FIELD_W-1:0] page,
                                         input logic lst);
        dir_row_t row;
        row      = '0;
        row.kind = ROW_REF;
        row.page = page;
        row.last = lst;
        return row;
    endfunction

    function automatic dir_row_t ref_exp(input logic [PAGE_FIELD_W-1:0] page,
                                         input logic lst, input logic h,
                                         input logic [SLOT_W-1:0] slot, input logic rv,
                                         input logic [PAGE_FIELD_W-1:0] rp,
                                         input logic [CNT_W-1:0] fc);
        dir_row_t row;
        row       = ref_row(page, lst);
        row.typed = 1'b1;
        row.want  = '{hit: h, frame_slot: slot, replaced_valid: rv,
                      replaced_page: rp, fault_count: fc};
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_W-1:0] frames);
        dir_row_t row;
        row        = '0;
        row.kind   = ROW_CFG;
        row.frames = frames;
        return row;
    endfunction

    // Stop offering and wait for every outstanding response
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] frames);
        drain();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.frames_in_use <= frames;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        frames_cfg = frames;
    endtask

    // Offer one reference; valid stays high after acceptance until the next gap
    task automatic send_ref(input logic [PAGE_FIELD_W-1:0] page, input logic lst,
                            input logic typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = idle_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.page_number <= page;
        req_ch.last_ref    <= lst;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = lru_access(page, lst);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic check_result();
        result_t want;
        resp_seen++;
        if (pending_results.size() == 0)
        begin
            $error("response with no request outstanding");
            mismatch_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (rsp_ch.hit !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, rsp_ch.hit);
                mismatch_count++;
            end
            if (rsp_ch.frame_slot !== want.frame_slot)
            begin
                $error("frame_slot: expected %0d, got %0d", want.frame_slot, rsp_ch.frame_slot);
                mismatch_count++;
            end
            if (rsp_ch.replaced_valid !== want.replaced_valid)
            begin
                $error("replaced_valid: expected %0d, got %0d",
                       want.replaced_valid, rsp_ch.replaced_valid);
                mismatch_count++;
            end
            if (rsp_ch.replaced_page !== want.replaced_page)
            begin
                $error("replaced_page: expected 0x%04h, got 0x%04h",
                       want.replaced_page, rsp_ch.replaced_page);
                mismatch_count++;
            end
            if (rsp_ch.fault_count !== want.fault_count)
            begin
                $error("fault_count: expected %0d, got %0d",
                       want.fault_count, rsp_ch.fault_count);
                mismatch_count++;
            end
        end
    endtask

    // Response side: random stalls, one long hold-off while requests keep coming
    initial
    begin
        int  stall_left;
        bit  held_off;
        stall_left = 0;
        held_off   = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                check_result();
            if (!held_off && resp_seen >= 150 && pending_results.size() != 0)
            begin
                held_off = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    // Stimulus
    initial
    begin
        dir_row_t                dir_rows [$];
        logic [PAGE_FIELD_W-1:0] pool [$];
        logic [PAGE_FIELD_W-1:0] page;
        logic [PAGE_FIELD_W-1:0] prev_page;
        logic [CFG_W-1:0]        frame_choices [10];
        logic                    lst;
        int                      sent_random;
        int                      n_strings;
        int                      len;
        int                      pick;

        mismatch_count = 0;
        resp_seen      = 0;
        no_gaps        = 1'b0;
        frames_cfg     = FRAMES_RESET;
        clear_frames();
        frame_choices = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd8, 5'd15, 5'd16, 5'd17, 5'd31};

        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.page_number   <= '0;
        req_ch.last_ref      <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.frames_in_use <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, field extremes, frame count clamps,
        // hidden frames, duplicate residency, string clear
        dir_rows = '{
            ref_exp(16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 32'd1),
            ref_exp(16'hFFFF, 1'b0, 1'b0, 4'd1, 1'b0, 16'h0000, 32'd2),
            ref_exp(16'h0000, 1'b0, 1'b1, 4'd0, 1'b0, 16'h0000, 32'd2),
            ref_exp(16'hA5A5, 1'b1, 1'b0, 4'd2, 1'b0, 16'h0000, 32'd3),
            cfg_row(5'd0),
            ref_exp(16'h1234, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 32'd1),
            ref_exp(16'h5678, 1'b0, 1'b0, 4'd0, 1'b1, 16'h1234, 32'd2),
            ref_exp(16'h5678, 1'b0, 1'b1, 4'd0, 1'b0, 16'h0000, 32'd2),
            cfg_row(5'd31),
            ref_row(16'h1234, 1'b0),
            ref_row(16'hBEEF, 1'b0),
            ref_row(16'h5A5A, 1'b0),
            cfg_row(5'd2),
            ref_row(16'h0F0F, 1'b0),
            ref_row(16'h1234, 1'b0),
            ref_row(16'hBEEF, 1'b0),
            cfg_row(5'd16),
            ref_row(16'hBEEF, 1'b0),
            ref_row(16'h5A5A, 1'b0),
            cfg_row(5'd1),
            ref_row(16'h8001, 1'b0),
            cfg_row(5'd17),
            ref_row(16'h7FFE, 1'b0),
            ref_row(16'hFFFF, 1'b1),
            ref_exp(16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, 16'h0000, 32'd1)
        };
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_frames(dir_rows[i].frames);
            else
                send_ref(dir_rows[i].page, dir_rows[i].last, dir_rows[i].typed,
                         dir_rows[i].want);
        end

        // Random phases of reference strings with locality, some noise
        sent_random = 0;
        prev_page   = '0;
        while (sent_random < 800)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 1) == 0)
                    write_frames(frame_choices[$urandom_range(0, 9)]);
                else
                    write_frames(CFG_W'($urandom_range(0, 31)));
            end
            no_gaps   = ($urandom_range(0, 3) == 0);
            n_strings = $urandom_range(1, 3);
            for (int s = 0; s < n_strings; s++)
            begin
                len = $urandom_range(1, 40);
                pool.delete();
                repeat ($urandom_range(1, 24))
                    pool.push_back(PAGE_FIELD_W'($urandom_range(0, 65535)));
                for (int k = 0; k < len; k++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 85)
                        page = pool[$urandom_range(0, pool.size() - 1)];
                    else if (pick < 95)
                        page = PAGE_FIELD_W'($urandom_range(0, 65535));
                    else
                        page = prev_page;
                    // string end, sometimes left open across a frame count change
                    if (k == len - 1)
                        lst = !(s == n_strings - 1 && $urandom_range(0, 3) == 0);
                    else
                        lst = ($urandom_range(0, 39) == 0);
                    send_ref(page, lst, 1'b0, '0);
                    prev_page = page;
                    sent_random++;
                end
            end
            drain();
        end

        // Settle: nothing further may arrive
        no_gaps = 1'b0;
        drain();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
src/lrupr_pkg.sv
src/lrupr_if.sv
src/lrupr_cell.sv
src/lrupr_ctrl.sv
src/lru_page_replacement_top.sv
tb/sv/tb_lru_page_replacement_top.sv
